// ----- hdl/assert_macros.svh -----
// assertion macros shared by the allocator rtl
// no dependencies; pulled in with an include by files that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BFFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bffa assertion failed");

// next-cycle implication, checked out of reset
`define BFFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bffa assertion failed");

`endif

// ----- hdl/bffa_pkg.sv -----
// shared constants, types and mask helper for the bitmap sector allocator
// no dependencies
package bffa_pkg;

  // map geometry
  localparam int SECTOR_COUNT = 65536;
  localparam int DIRBAND_MAX  = 16384;
  localparam int WORD_BITS    = 32;
  localparam int OFF_W        = $clog2(WORD_BITS);
  localparam int LEN_W        = OFF_W + 1;
  localparam int MAP_WORDS    = SECTOR_COUNT / WORD_BITS;
  localparam int MAP_AW       = $clog2(MAP_WORDS);
  localparam int POS_W        = $clog2(SECTOR_COUNT) + 1;

  // operation codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_DIR   = 2'd1;
  localparam logic [1:0] FUNC_MARK  = 2'd2;
  localparam logic [1:0] FUNC_SET   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PARTITION = 2'd0;
  localparam logic [1:0] REG_DIR_START = 2'd1;
  localparam logic [1:0] REG_DIR_LEN   = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SKIP_RD,
    ST_SKIP,
    ST_FIT_RD,
    ST_FIT,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_DONE
  } state_e;

  // request to the shared run-length scanner
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [MAP_AW-1:0]    widx;
    logic [OFF_W-1:0]     offset;
    logic [POS_W-1:0]     lim;
    logic                 match_one;
  } scan_req_t;

  // bits of word widx whose sector lies in [lo, hi)
  function automatic logic [WORD_BITS-1:0] range_mask(logic [MAP_AW-1:0] widx,
                                                      logic [POS_W-1:0]  lo,
                                                      logic [POS_W-1:0]  hi);
    logic [POS_W-1:0]     base;
    logic [POS_W-1:0]     top;
    logic [LEN_W-1:0]     lo_off;
    logic [LEN_W-1:0]     hi_off;
    logic [WORD_BITS-1:0] lo_m;
    logic [WORD_BITS-1:0] hi_m;
    base = POS_W'({widx, OFF_W'(0)});
    top  = base + POS_W'(WORD_BITS);
    if (lo <= base)     lo_off = '0;
    else if (lo >= top) lo_off = LEN_W'(WORD_BITS);
    else                lo_off = LEN_W'(lo - base);
    if (hi <= base)     hi_off = '0;
    else if (hi >= top) hi_off = LEN_W'(WORD_BITS);
    else                hi_off = LEN_W'(hi - base);
    lo_m = lo_off[OFF_W] ? '0 : ({WORD_BITS{1'b1}} << lo_off[OFF_W-1:0]);
    hi_m = hi_off[OFF_W] ? '0 : ({WORD_BITS{1'b1}} << hi_off[OFF_W-1:0]);
    return lo_m & ~hi_m;
  endfunction

endpackage

// ----- hdl/bitmap_first_fit_sector_allocator_top.sv -----
// top level of the bitmap first-fit sector allocator: sequencer and datapath
// depends on bffa_pkg, bffa_ram, bffa_scan and assert_macros.svh
//
//   channel  signals                                 direction
//   in       in_valid_i/in_ready_o, func/count/sector  to block
//   out      out_valid_o/out_ready_i, start_sector/status from block
//   cfg      cfg_we_i, cfg_index_i, cfg_data_i          to block
//
// after reset a clearing pass writes the 2048-word free map, with in_ready_o low
// alloc: scan steps, each a ram read then the shared scanner (a word of used sectors while
//   skipping; a free run in a word, or a single used sector, while fitting), then
//   a ram read-modify-write per map word marked
// mark: a ram read-modify-write per map word touched; dirband without fallback and set start go straight to the result
// a finished word waits in the output register; the next word is taken meanwhile
`include "assert_macros.svh"

module bitmap_first_fit_sector_allocator_top import bffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [14:0] count_i,
  input  logic [15:0] sector_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] start_sector_o,
  output logic        status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  function automatic logic [MAP_AW-1:0] word_of(logic [POS_W-1:0] p);
    return p[MAP_AW+OFF_W-1:OFF_W];
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [16:0] part_q;
  logic [15:0] dstart_q;
  logic [13:0] dlen_q;

  // allocator state and work registers
  logic [POS_W-1:0]  ss_q, ss_d;
  logic [13:0]       dused_q, dused_d;
  logic [14:0]       count_q, count_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  first_q, first_d;
  logic [14:0]       run_q, run_d;
  logic [POS_W-1:0]  mlo_q, mlo_d;
  logic [POS_W-1:0]  mhi_q, mhi_d;
  logic [MAP_AW-1:0] mw_q, mw_d;
  logic [MAP_AW-1:0] mlast_q, mlast_d;
  logic [MAP_AW-1:0] clr_q;
  logic [15:0]       res_start_q, res_start_d;
  logic              res_fail_q, res_fail_d;
  logic              out_valid_q, out_valid_d;
  logic [15:0]       out_start_q, out_start_d;
  logic              out_status_q, out_status_d;

  // ram and scanner
  logic                 ram_we, ram_re;
  logic [MAP_AW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
  scan_req_t            scan_req;
  logic [LEN_W-1:0]     scan_len;

  // shared conditions
  logic [POS_W-1:0] lim;
  logic             in_acc;
  logic             ss_ge_lim, pos_ge_lim;
  logic             scan_end;
  logic [POS_W-1:0] skip_nxt;
  logic             skip_past;
  logic [14:0]      need;
  logic             fit_ok;
  logic [POS_W-1:0] fit_first;
  logic [POS_W-1:0] fit_end;
  logic [15:0]      dir_sum;
  logic             dir_fb;
  logic [16:0]      dir_base;
  logic [17:0]      dir_top;
  logic             dir_fail;
  logic [POS_W-1:0] mk_end;
  logic [POS_W-1:0] mk_hi;
  logic             mk_fail;
  logic             mk_empty;
  logic             out_go;
  logic             clr_last;

  bffa_ram #(.AW(MAP_AW), .DW(WORD_BITS)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bffa_scan u_scan (
    .req_i (scan_req),
    .len_o (scan_len)
  );

  // effective limit and condition terms
  assign lim = (32'(part_q) < 32'(SECTOR_COUNT)) ? POS_W'(part_q) : POS_W'(SECTOR_COUNT);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign ss_ge_lim  = ss_q >= lim;
  assign pos_ge_lim = pos_q >= lim;
  assign scan_end   = (LEN_W'(scan_req.offset) + scan_len) == LEN_W'(WORD_BITS);
  assign skip_nxt   = ss_q + POS_W'(scan_len);
  assign skip_past  = skip_nxt >= lim;
  assign need       = count_q - run_q;
  assign fit_ok     = 15'(scan_len) >= need;
  assign fit_first  = (run_q == '0) ? pos_q : first_q;
  assign fit_end    = fit_first + POS_W'(count_q);
  assign dir_sum    = 16'(dused_q) + 16'(count_i);
  assign dir_fb     = dir_sum >= 16'(dlen_q);
  assign dir_base   = 17'(dstart_q) + 17'(dused_q);
  assign dir_top    = 18'(dir_base) + 18'(count_i);
  assign dir_fail   = (dir_top > 18'(lim)) || (dir_sum > 16'(DIRBAND_MAX));
  assign mk_end     = POS_W'(sector_i) + POS_W'(count_i);
  assign mk_hi      = (mk_end > lim) ? lim : mk_end;
  assign mk_fail    = (count_i != '0) && (mk_end > lim);
  assign mk_empty   = POS_W'(sector_i) >= mk_hi;
  assign out_go     = !out_valid_q || out_ready_i;
  assign clr_last   = clr_q == MAP_AW'(MAP_WORDS - 1);

  // scanner request: skip used sectors, or measure a free run
  always_comb begin
    scan_req.word      = ram_rdata;
    scan_req.lim       = lim;
    scan_req.match_one = state_q == ST_FIT;
    if (state_q == ST_FIT) begin
      scan_req.widx   = word_of(pos_q);
      scan_req.offset = pos_q[OFF_W-1:0];
    end else begin
      scan_req.widx   = word_of(ss_q);
      scan_req.offset = ss_q[OFF_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (func_i)
            FUNC_ALLOC: state_d = ST_SKIP_RD;
            FUNC_DIR:   state_d = dir_fb ? ST_SKIP_RD : ST_DONE;
            FUNC_MARK:  state_d = mk_empty ? ST_DONE : ST_MARK_RD;
            FUNC_SET:   state_d = ST_DONE;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_SKIP_RD: state_d = ss_ge_lim ? ST_DONE : ST_SKIP;
      ST_SKIP: begin
        if (!scan_end)      state_d = (count_q == '0) ? ST_DONE : ST_FIT_RD;
        else if (skip_past) state_d = ST_DONE;
        else                state_d = ST_SKIP_RD;
      end
      ST_FIT_RD:  state_d = pos_ge_lim ? ST_DONE : ST_FIT;
      ST_FIT:     state_d = fit_ok ? ST_MARK_RD : ST_FIT_RD;
      ST_MARK_RD: state_d = ST_MARK_WR;
      ST_MARK_WR: state_d = (mw_q == mlast_q) ? ST_DONE : ST_MARK_RD;
      ST_DONE:    if (out_go) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // state outputs: handshake and ram control
  always_comb begin
    in_ready_o = state_q == ST_IDLE;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = mw_q;
    ram_raddr  = mw_q;
    ram_wdata  = ram_rdata & ~range_mask(mw_q, mlo_q, mhi_q);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '1;
      end
      ST_SKIP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = word_of(ss_q);
      end
      ST_FIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = word_of(pos_q);
      end
      ST_MARK_RD: ram_re = 1'b1;
      ST_MARK_WR: ram_we = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    ss_d        = ss_q;
    dused_d     = dused_q;
    count_d     = count_q;
    pos_d       = pos_q;
    first_d     = first_q;
    run_d       = run_q;
    mlo_d       = mlo_q;
    mhi_d       = mhi_q;
    mw_d        = mw_q;
    mlast_d     = mlast_q;
    res_start_d = res_start_q;
    res_fail_d  = res_fail_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          count_d     = count_i;
          res_start_d = '0;
          res_fail_d  = 1'b0;
          unique case (func_i)
            FUNC_DIR: begin
              if (!dir_fb) begin
                if (dir_fail) begin
                  res_fail_d = 1'b1;
                end else begin
                  dused_d     = dir_sum[13:0];
                  res_start_d = dir_base[15:0];
                end
              end
            end
            FUNC_MARK: begin
              res_fail_d = mk_fail;
              mlo_d      = POS_W'(sector_i);
              mhi_d      = mk_hi;
              mw_d       = word_of(POS_W'(sector_i));
              mlast_d    = word_of(mk_hi - POS_W'(1));
            end
            FUNC_SET: ss_d = POS_W'(sector_i);
            default: ;
          endcase
        end
      end
      ST_SKIP_RD: if (ss_ge_lim) res_fail_d = 1'b1;
      ST_SKIP: begin
        // first free sector found in this word
        if (!scan_end) begin
          ss_d = skip_nxt;
          if (count_q == '0) begin
            res_start_d = skip_nxt[15:0];
          end else begin
            pos_d   = skip_nxt;
            first_d = skip_nxt;
            run_d   = '0;
          end
        end else if (skip_past) begin
          ss_d       = lim;
          res_fail_d = 1'b1;
        end else begin
          ss_d = skip_nxt;
        end
      end
      ST_FIT_RD: if (pos_ge_lim) res_fail_d = 1'b1;
      ST_FIT: begin
        if (fit_ok) begin
          // run complete: set up the marking sweep
          res_start_d = fit_first[15:0];
          mlo_d       = fit_first;
          mhi_d       = fit_end;
          mw_d        = word_of(fit_first);
          mlast_d     = word_of(fit_end - POS_W'(1));
        end else if (scan_end) begin
          // run carries into the next word
          run_d   = run_q + 15'(scan_len);
          first_d = fit_first;
          pos_d   = pos_q + POS_W'(scan_len);
        end else begin
          // used sector breaks the run; restart just past it
          run_d = '0;
          pos_d = pos_q + POS_W'(scan_len) + POS_W'(1);
        end
      end
      ST_MARK_WR: mw_d = mw_q + MAP_AW'(1);
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_start_d  = out_start_q;
    out_status_d = out_status_q;
    if (state_q == ST_DONE && out_go) begin
      out_valid_d  = 1'b1;
      out_start_d  = res_start_q;
      out_status_d = res_fail_q;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ss_q        <= '0;
      dused_q     <= '0;
      out_valid_q <= 1'b0;
      part_q      <= 17'h10000;
      dstart_q    <= '0;
      dlen_q      <= '0;
    end else begin
      state_q     <= state_d;
      ss_q        <= ss_d;
      dused_q     <= dused_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + MAP_AW'(1);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PARTITION: part_q   <= cfg_data_i;
          REG_DIR_START: dstart_q <= cfg_data_i[15:0];
          REG_DIR_LEN:   dlen_q   <= cfg_data_i[13:0];
          default: ;
        endcase
      end
    end
  end

  // work and payload registers
  always_ff @(posedge clk_i) begin
    count_q      <= count_d;
    pos_q        <= pos_d;
    first_q      <= first_d;
    run_q        <= run_d;
    mlo_q        <= mlo_d;
    mhi_q        <= mhi_d;
    mw_q         <= mw_d;
    mlast_q      <= mlast_d;
    res_start_q  <= res_start_d;
    res_fail_q   <= res_fail_d;
    out_start_q  <= out_start_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign start_sector_o = out_start_q;
  assign status_o       = out_status_q;

  // checks
  `BFFA_ASSERT_NXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `BFFA_ASSERT_IMP(a_fail_zero_start, clk_i, rst_ni, out_valid_o && status_o,
                   start_sector_o == '0)
  `BFFA_ASSERT_IMP(a_run_below_count, clk_i, rst_ni, state_q == ST_FIT, run_q < count_q)

endmodule

// ----- hdl/bffa_ram.sv -----
// simple dual-port ram: one write port, one read port with registered data
// no dependencies
module bffa_ram #(
  parameter int AW = 11,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- hdl/bffa_scan.sv -----
// shared scanner: length of the run of like bits from an offset in one map word
// depends on bffa_pkg; sectors at or past the limit read as used
module bffa_scan import bffa_pkg::*; (
  input  scan_req_t        req_i,
  output logic [LEN_W-1:0] len_o
);

  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] masked;
  logic [WORD_BITS-1:0] sel;
  logic [WORD_BITS-1:0] shifted;

  // clip to the partition limit, pick polarity, align to offset
  assign lim_mask = range_mask(req_i.widx, '0, req_i.lim);
  assign masked   = req_i.word & lim_mask;
  assign sel      = req_i.match_one ? masked : ~masked;
  assign shifted  = sel >> req_i.offset;

  // lowest clear bit of the aligned word; zero fill stops the run at word end
  always_comb begin
    len_o = LEN_W'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!shifted[i]) len_o = LEN_W'(i);
    end
  end

endmodule

// ----- verif/bffa_result_checker.sv -----
`timescale 1ns / 100ps
// result checker for the bitmap first-fit sector allocator: watches the word channels
// and register writes, predicts each result word and compares it; depends on bffa_pkg
module bffa_result_checker import bffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [14:0] count_i,
  input  logic [15:0] sector_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] start_sector_i,
  input  logic        status_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [15:0] start_sector;
    logic        status;
  } alloc_word_t;

  // shadow of the allocator state and registers
  bit          sector_free [SECTOR_COUNT];
  int unsigned search_ptr;
  int unsigned band_used;
  int unsigned part_sectors;
  int unsigned band_start;
  int unsigned band_len;

  alloc_word_t awaited_words [$];
  int          fail_count;
  int          word_count;

  function automatic int unsigned usable_limit();
    return (part_sectors < SECTOR_COUNT) ? part_sectors : SECTOR_COUNT;
  endfunction

  // skip used sectors at the pointer, then lowest run of cnt free sectors
  function automatic bit first_fit(input int unsigned cnt, output int unsigned run_start);
    int unsigned lim;
    int unsigned run_len;
    lim       = usable_limit();
    run_len   = 0;
    run_start = 0;
    while (search_ptr < lim && !sector_free[search_ptr]) search_ptr++;
    if (search_ptr >= lim) return 1'b0;
    if (cnt == 0) begin
      run_start = search_ptr;
      return 1'b1;
    end
    for (int unsigned s = search_ptr; s < lim; s++) begin
      if (sector_free[s]) begin
        if (run_len == 0) run_start = s;
        run_len++;
        if (run_len == cnt) begin
          for (int unsigned k = run_start; k < run_start + cnt; k++) sector_free[k] = 1'b0;
          return 1'b1;
        end
      end else begin
        // used sector: restart just past it
        run_len = 0;
      end
    end
    return 1'b0;
  endfunction

  // expected result word for one accepted request, updating the shadow state
  function automatic alloc_word_t predict_word(input logic [1:0]  op,
                                               input logic [14:0] cnt,
                                               input logic [15:0] sec);
    alloc_word_t w;
    int unsigned first;
    int unsigned lim;
    bit          ok;
    first = 0;
    ok    = 1'b1;
    lim   = usable_limit();
    case (op)
      FUNC_ALLOC: ok = first_fit(cnt, first);
      FUNC_DIR: begin
        if (band_used + cnt >= band_len) begin
          // band would fill up: served by the main allocator
          ok = first_fit(cnt, first);
        end else if (band_start + band_used + cnt > lim || band_used + cnt > DIRBAND_MAX) begin
          ok = 1'b0;
        end else begin
          first     = band_start + band_used;
          band_used = (band_used + cnt) & 32'h3FFF;
        end
      end
      FUNC_MARK: begin
        for (int unsigned k = 0; k < cnt; k++) begin
          if (sec + k >= lim) begin
            ok = 1'b0;
            break;
          end
          sector_free[sec + k] = 1'b0;
        end
      end
      FUNC_SET: search_ptr = sec;
    endcase
    if (!ok || op == FUNC_MARK || op == FUNC_SET) first = 0;
    w.start_sector = first[15:0];
    w.status       = !ok;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_words
    alloc_word_t want;
    if (!rst_ni) begin
      foreach (sector_free[i]) sector_free[i] = 1'b1;
      search_ptr   = 0;
      band_used    = 0;
      part_sectors = SECTOR_COUNT;
      band_start   = 0;
      band_len     = 0;
      awaited_words.delete();
      fail_count   = 0;
      word_count   = 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PARTITION: part_sectors = cfg_data_i;
          REG_DIR_START: band_start   = cfg_data_i[15:0];
          REG_DIR_LEN:   band_len     = cfg_data_i[13:0];
          default: ;
        endcase
      end
      // result side before request side, a word never answers its own edge
      if (out_valid_i && out_ready_i) begin
        word_count++;
        if (awaited_words.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result word %0d with nothing awaited: start_sector %0d status %0d",
                     word_count, start_sector_i, status_i);
        end else begin
          want = awaited_words.pop_front();
          if (start_sector_i !== want.start_sector || status_i !== want.status) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("result word %0d: start_sector exp %0d got %0d, status exp %0d got %0d",
                       word_count, want.start_sector, start_sector_i, want.status, status_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_words.push_back(predict_word(func_i, count_i, sector_i));
    end
    fail_count_o <= fail_count;
    pending_o    <= awaited_words.size();
  end

endmodule

// ----- verif/bitmap_first_fit_sector_allocator_top_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the bitmap first-fit sector allocator: clock, reset, register
// setup, request words under several idling phases and the verdict
// depends on bffa_pkg, the allocator rtl and bffa_result_checker
module bitmap_first_fit_sector_allocator_top_tb;
  import bffa_pkg::*;

  localparam int STALL_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 6;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  func      = FUNC_ALLOC;
  logic [14:0] count     = '0;
  logic [15:0] sector    = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] start_sector;
  logic        status;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = REG_PARTITION;
  logic [16:0] cfg_data  = '0;

  int          fail_count;
  int          pending;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  bit          hold_req       = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned cur_limit      = SECTOR_COUNT;
  int          sent_per_op [4] = '{0, 0, 0, 0};
  int          settings_used  = 0;

  bitmap_first_fit_sector_allocator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .count_i        (count),
    .sector_i       (sector),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .start_sector_o (start_sector),
    .status_o       (status),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  bffa_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .func_i         (func),
    .count_i        (count),
    .sector_i       (sector),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .start_sector_i (start_sector),
    .status_i       (status),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // offer one request word and hold it until taken
  task automatic send_word(input logic [1:0] op, input int unsigned cnt, input int unsigned sec);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func     <= op;
    count    <= cnt[14:0];
    sector   <= sec[15:0];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent_per_op[op]++;
  endtask

  // wait until every result word is back and the block takes requests
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || !in_ready);
  endtask

  // program all three registers while the block is idle
  task automatic program_regs(input int unsigned part, input int unsigned dstart,
                              input int unsigned dlen);
    wait_idle();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PARTITION;
    cfg_data  <= part[16:0];
    @(posedge clk_i);
    cfg_index <= REG_DIR_START;
    cfg_data  <= dstart[16:0];
    @(posedge clk_i);
    cfg_index <= REG_DIR_LEN;
    cfg_data  <= dlen[16:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_limit = (part < SECTOR_COUNT) ? part : SECTOR_COUNT;
    settings_used++;
  endtask

  // random request: mostly small runs, rare large ones, positions biased into the partition
  task automatic send_random_word();
    int unsigned pick;
    int unsigned cnt;
    int unsigned sec;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 42)      op = FUNC_ALLOC;
    else if (pick < 67) op = FUNC_DIR;
    else if (pick < 87) op = FUNC_MARK;
    else                op = FUNC_SET;
    pick = $urandom_range(0, 99);
    if (pick < 6)       cnt = 0;
    else if (pick < 80) cnt = $urandom_range(1, 16);
    else if (pick < 99) cnt = $urandom_range(17, 128);
    else                cnt = $urandom_range(129, 16384);
    if ($urandom_range(0, 1)) sec = $urandom_range(0, cur_limit - 1);
    else                      sec = $urandom_range(0, 65535);
    send_word(op, cnt, sec);
  endtask

  // result side: random stalls, or one long hold when asked
  initial begin : result_sink
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        @(posedge clk_i);
      end
    end
  end

  // give up when no word moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_part   [PHASES];
    int unsigned phase_dstart [PHASES];
    int unsigned phase_dlen   [PHASES];
    int          phase_send   [PHASES];
    int          phase_recv   [PHASES];
    int          phase_words  [PHASES];
    phase_part      = '{1, 12000, 30000, 49000, 65536, 65536};
    phase_dstart    = '{0, 65535, 0, 0, 47000, 0};
    phase_dlen      = '{0, 16380, 300, 0, 2000, 16380};
    phase_send      = '{18, 0, 49, 0, 18, 0};
    phase_recv      = '{18, 0, 0, 49, 18, 0};
    phase_words     = '{100, 300, 350, 350, 350, 380};
    phase_dstart[2] = $urandom_range(0, 29000);
    phase_dstart[3] = $urandom_range(0, 65535);
    phase_dlen[3]   = $urandom_range(0, 16380);

    // reset once
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // directed part: band of 100 sectors at 60000
    program_regs(65536, 60000, 100);
    send_word(FUNC_ALLOC, 0, 0);        // zero count: first free sector, nothing marked
    send_word(FUNC_ALLOC, 1, 0);
    send_word(FUNC_MARK, 2, 1);
    send_word(FUNC_MARK, 1, 6);
    send_word(FUNC_ALLOC, 4, 0);        // run broken at 6, restarts past it
    send_word(FUNC_SET, 0, 49000);
    send_word(FUNC_ALLOC, 16384, 0);    // largest run
    send_word(FUNC_MARK, 16384, 65000); // mark running past the partition
    send_word(FUNC_SET, 0, 65535);
    send_word(FUNC_ALLOC, 0, 0);        // pointer runs off the end
    send_word(FUNC_SET, 0, 0);
    send_word(FUNC_ALLOC, 3, 0);
    send_word(FUNC_SET, 0, 40000);
    send_word(FUNC_ALLOC, 16384, 0);    // no fitting run, pointer keeps its place
    send_word(FUNC_DIR, 10, 0);
    send_word(FUNC_DIR, 0, 0);
    send_word(FUNC_DIR, 89, 0);
    send_word(FUNC_DIR, 1, 0);          // band full: falls back to main alloc
    send_word(FUNC_MARK, 0, 65535);
    send_word(FUNC_ALLOC, 7, 12345);

    // band running past the end of the partition
    program_regs(65536, 65530, 16380);
    send_word(FUNC_DIR, 5, 0);
    send_word(FUNC_DIR, 0, 0);
    send_word(FUNC_SET, 0, 0);

    // random phases over several register settings and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      program_regs(phase_part[p], phase_dstart[p], phase_dlen[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (p == PHASES - 1) hold_req = 1'b1;
      repeat (phase_words[p]) send_random_word();
    end

    // drain and settle
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d request words over %0d register settings",
             sent_per_op[0] + sent_per_op[1] + sent_per_op[2] + sent_per_op[3],
             settings_used);
    $display("alloc %0d, dirband %0d, mark %0d, set start %0d; idling: none, sender only,",
             sent_per_op[FUNC_ALLOC], sent_per_op[FUNC_DIR], sent_per_op[FUNC_MARK],
             sent_per_op[FUNC_SET]);
    $display("receiver only, both, and one %0d-cycle result hold", HOLD_CYCLES);
    if (fail_count == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
